FILE: rtl/core/rcsi_pkg.sv
// Shared types and constants for the rank-counting sorted insert core.
`timescale 1ns / 1ps

package rcsi_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 16;
    localparam int IN_VALUE_BITS  = 16;
    localparam int COUNT_BITS     = 11;

    // Control flags of an item travelling down the cell chain
    typedef struct packed {
        logic valid;   // slot holds an item
        logic clear;   // item empties each cell it passes
        logic search;  // still counting smaller entries
        logic place;   // carried data still needs a home
        logic full;    // store was full on entry
    } rcsi_tok_t;

endpackage

FILE: rtl/core/rcsi_cell.sv
// One compare-and-shift cell of the sorted store chain.
`timescale 1ns / 1ps

module rcsi_cell #(
    parameter int VALUE_BITS = 16,
    parameter int CNT_BITS   = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  rcsi_pkg::rcsi_tok_t          tok_in,
    input  logic signed [VALUE_BITS-1:0] data_in,
    input  logic [CNT_BITS-1:0]          count_in,
    output rcsi_pkg::rcsi_tok_t          tok_out,
    output logic signed [VALUE_BITS-1:0] data_out,
    output logic [CNT_BITS-1:0]          count_out
);
    import rcsi_pkg::*;

    logic                         held_valid_reg;
    logic                         held_valid_next;
    logic signed [VALUE_BITS-1:0] held_data_reg;
    logic signed [VALUE_BITS-1:0] held_data_next;
    rcsi_tok_t                    tok_reg;
    rcsi_tok_t                    tok_next;
    logic signed [VALUE_BITS-1:0] data_reg;
    logic signed [VALUE_BITS-1:0] data_next;
    logic [CNT_BITS-1:0]          count_reg;
    logic [CNT_BITS-1:0]          count_next;

    logic cur_valid;
    logic lt;
    logic take;

    always_comb
    begin
        cur_valid       = held_valid_reg & ~(tok_in.valid & tok_in.clear);
        lt              = cur_valid && (held_data_reg < data_in);
        // the item settles here once no longer passing smaller entries
        take            = tok_in.valid && tok_in.place && !(tok_in.search && lt);
        held_valid_next = tok_in.valid ? (cur_valid | take) : held_valid_reg;
        held_data_next  = take ? data_in : held_data_reg;
        tok_next        = tok_in;
        tok_next.search = tok_in.search & lt;
        tok_next.place  = take ? cur_valid : tok_in.place;
        data_next       = take ? held_data_reg : data_in;
        count_next      = (tok_in.valid && tok_in.search && lt) ? count_in + 1'b1 : count_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            tok_reg        <= '0;
        end
        else if (en)
        begin
            held_valid_reg <= held_valid_next;
            tok_reg        <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            held_data_reg <= held_data_next;
            data_reg      <= data_next;
            count_reg     <= count_next;
        end
    end

    assign tok_out   = tok_reg;
    assign data_out  = data_reg;
    assign count_out = count_reg;

endmodule

FILE: rtl/core/rank_counting_sorted_insert_core.sv
// Top level: rank-counting sorted store built as a systolic cell chain.
//
// Input channel in_valid/in_ready carries value and first; output channel
// out_valid/out_ready carries smaller_count and store_full, one result per
// item, in input order. Feed the sequence last element first; smaller_count
// is the number of values held that are strictly smaller than value.
// first=1 empties the store ahead of that item.
// Each item walks the chain of CAPACITY cells, one cell per cycle while the
// chain is not held, counting smaller entries and then shifting larger ones
// up a place. out_valid rises once the item has passed through the registers
// of every cell; while the receiver keeps up a new item is accepted every
// cycle, so throughput is one item per cycle.
// A full store still reports the count; the value is dropped, store_full=1.
// Reset empties the store at once: no clearing pass.
// When the receiver stalls with a result waiting, the whole chain holds
// and in_ready falls in the same cycle; nothing is lost.
`timescale 1ns / 1ps

module rank_counting_sorted_insert_core #(
    parameter int CAPACITY   = rcsi_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = rcsi_pkg::VALUE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [rcsi_pkg::IN_VALUE_BITS-1:0] value,
    input  logic                                 first,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rcsi_pkg::COUNT_BITS-1:0]      smaller_count,
    output logic                                 store_full
);
    import rcsi_pkg::*;

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    logic                         en;
    logic                         accept;
    logic [CNT_BITS-1:0]          fill_reg;
    logic [CNT_BITS-1:0]          fill_next;
    logic [CNT_BITS-1:0]          fill_base;
    logic                         is_full;
    logic signed [VALUE_BITS-1:0] v_ext;

    rcsi_tok_t                    tok   [CAPACITY+1];
    logic signed [VALUE_BITS-1:0] data  [CAPACITY+1];
    logic [CNT_BITS-1:0]          count [CAPACITY+1];
    logic [CNT_BITS+COUNT_BITS-1:0] count_ext;

    assign en       = !tok[CAPACITY].valid || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && in_ready;

    generate
        if (VALUE_BITS <= IN_VALUE_BITS)
        begin : g_narrow
            assign v_ext = value[VALUE_BITS-1:0];
        end
        else
        begin : g_wide
            assign v_ext = {{(VALUE_BITS-IN_VALUE_BITS){value[IN_VALUE_BITS-1]}}, value};
        end
    endgenerate

    // head-of-chain fill count decides whether this item is inserted
    always_comb
    begin
        fill_base = first ? '0 : fill_reg;
        is_full   = (fill_base == CNT_BITS'(CAPACITY));
        fill_next = is_full ? fill_base : fill_base + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    always_comb
    begin
        tok[0].valid  = in_valid;
        tok[0].clear  = first;
        tok[0].search = 1'b1;
        tok[0].place  = !is_full;
        tok[0].full   = is_full;
        data[0]       = v_ext;
        count[0]      = '0;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            rcsi_cell #(
                .VALUE_BITS (VALUE_BITS),
                .CNT_BITS   (CNT_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .tok_in    (tok[i]),
                .data_in   (data[i]),
                .count_in  (count[i]),
                .tok_out   (tok[i+1]),
                .data_out  (data[i+1]),
                .count_out (count[i+1])
            );
        end
    endgenerate

    // displaced value leaving the last cell has no home and is dropped
    assign count_ext     = {{COUNT_BITS{1'b0}}, count[CAPACITY]};
    assign out_valid     = tok[CAPACITY].valid;
    assign smaller_count = count_ext[COUNT_BITS-1:0];
    assign store_full    = tok[CAPACITY].full;

endmodule
